>>> rtl/core/vtm_pkg.sv
// ----------------------------------------------------------------------------
// vtm_pkg : shared definitions for the virtual timer multiplexer
// Slot table sizing, opcodes, event kinds and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vtm_pkg;

    // Table sizing
    localparam int NUM_SLOTS = 16;
    localparam int MAX_FIRES = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int FCNT_W    = $clog2(MAX_FIRES + 1);

    // Field widths of the ports
    localparam int OP_W   = 2;
    localparam int TIME_W = 32;
    localparam int ID_W   = 4;
    localparam int KIND_W = 3;

    // Opcodes (the unused code behaves as a tick)
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_STARTED     = 3'd0;
    localparam logic [KIND_W-1:0] EV_FULL        = 3'd1;
    localparam logic [KIND_W-1:0] EV_CANCELLED   = 3'd2;
    localparam logic [KIND_W-1:0] EV_NOT_ACTIVE  = 3'd3;
    localparam logic [KIND_W-1:0] EV_FIRED       = 3'd4;

    typedef logic [SLOT_W-1:0] slot_t;

    // Commands from the controller
    typedef struct packed {
        logic do_start;    // take a start beat from the input ports
        logic do_cancel;   // take a cancel beat from the input ports
        logic do_tick;     // advance the counter, clear the fired set
        logic scan_begin;  // restart a scan of the slot table
        logic scan_step;   // run one scan cycle
        logic fire_read;   // latch the best slot, read its period
        logic fire_write;  // reschedule or free the latched slot
        logic emit_fire;   // load a fire event into the output register
        logic emit_last;   // force last on that fire event
    } vtm_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic scan_done;   // scan finished, best slot settled
        logic found;       // a due, not yet fired slot was found
        logic have_fired;  // a fire of this tick awaits its event
        logic cap_hit;     // the fire under way is the final one allowed
        logic out_last;    // output register holds a last event
    } vtm_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/vtm_ctrl.sv
// ----------------------------------------------------------------------------
// vtm_ctrl : sequencing controller
// Decodes each input beat and steps the datapath through scans, fires and
// output handshakes, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module vtm_ctrl
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [vtm_pkg::OP_W-1:0] opcode,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output vtm_pkg::vtm_cmd_t            cmd,
    input  wire vtm_pkg::vtm_sts_t       sts
);
    import vtm_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_PICK    = 3'd2;
    localparam logic [2:0] ST_FIRE_RD = 3'd3;
    localparam logic [2:0] ST_FIRE_WR = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode the state into commands and the next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (opcode == OP_START)
                    begin
                        cmd.do_start = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else if (opcode == OP_CANCEL)
                    begin
                        cmd.do_cancel = 1'b1;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        cmd.do_tick    = 1'b1;
                        cmd.scan_begin = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                priority if (sts.have_fired)
                begin
                    cmd.emit_fire = 1'b1;
                    state_next    = ST_OUT;
                end
                else if (sts.found)
                begin
                    state_next = ST_FIRE_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIRE_RD:
            begin
                cmd.fire_read = 1'b1;
                state_next    = ST_FIRE_WR;
            end
            ST_FIRE_WR:
            begin
                cmd.fire_write = 1'b1;
                if (sts.cap_hit)
                begin
                    cmd.emit_fire = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.scan_begin = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_FIRE_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/vtm_dp.sv
// ----------------------------------------------------------------------------
// vtm_dp : timer table datapath
// Holds the counter, the slot table and its expiry and period memories,
// scans one slot per cycle for the oldest due timer and builds each event.
// ----------------------------------------------------------------------------
`default_nettype none

module vtm_dp
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [vtm_pkg::TIME_W-1:0] duration,
    input  wire logic                       repeat_flag,
    input  wire logic [vtm_pkg::ID_W-1:0]   cancel_id,
    output logic [vtm_pkg::KIND_W-1:0]      event_kind,
    output logic [vtm_pkg::ID_W-1:0]        slot_id,
    output logic [vtm_pkg::TIME_W-1:0]      time_now,
    output logic                            last,
    input  wire vtm_pkg::vtm_cmd_t          cmd,
    output vtm_pkg::vtm_sts_t               sts
);
    import vtm_pkg::*;

    // Control state
    logic [TIME_W-1:0]    counter_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] done_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic                 rd_valid_reg;
    logic                 found_reg;
    logic                 have_fired_reg;
    logic [FCNT_W-1:0]    fire_cnt_reg;

    // Payload state
    logic [TIME_W-1:0]    exp_mem [NUM_SLOTS];
    logic [TIME_W-1:0]    per_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] repeat_reg;
    logic [TIME_W-1:0]    exp_rd_reg;
    logic [TIME_W-1:0]    per_rd_reg;
    slot_t                rd_slot_reg;
    slot_t                best_reg;
    logic [TIME_W-1:0]    best_age_reg;
    slot_t                fired_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 last_reg;

    // Combinational helpers
    slot_t             free_slot;
    logic              any_free;
    slot_t             cancel_slot;
    logic              cancel_ok;
    logic              scan_run;
    slot_t             scan_slot;
    logic [TIME_W-1:0] age;
    logic              cand;
    logic              exp_we;
    slot_t             exp_wa;
    logic [TIME_W-1:0] exp_wd;

    // Find the lowest free slot
    always_comb
    begin
        free_slot = '0;
        any_free  = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_slot = slot_t'(i);
                any_free  = 1'b1;
            end
        end
    end

    // Check the cancel target
    assign cancel_slot = slot_t'(cancel_id);
    assign cancel_ok   = (32'(cancel_id) < NUM_SLOTS) && active_reg[cancel_slot];

    // Scan addressing and due test for the slot read last cycle
    assign scan_run  = cmd.scan_step && (scan_cnt_reg < CNT_W'(NUM_SLOTS));
    assign scan_slot = scan_cnt_reg[SLOT_W-1:0];
    assign age       = counter_reg - exp_rd_reg;
    assign cand      = rd_valid_reg && active_reg[rd_slot_reg] && !done_reg[rd_slot_reg]
                       && !age[TIME_W-1];

    // Select the expiry write: new timer or reschedule
    always_comb
    begin
        exp_we = 1'b0;
        exp_wa = fired_reg;
        exp_wd = counter_reg + per_rd_reg;
        if (cmd.do_start && any_free)
        begin
            exp_we = 1'b1;
            exp_wa = free_slot;
            exp_wd = counter_reg + duration;
        end
        else if (cmd.fire_write && repeat_reg[fired_reg])
        begin
            exp_we = 1'b1;
        end
    end

    // Memories and payload registers
    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[exp_wa] <= exp_wd;
        end
        if (cmd.do_start && any_free)
        begin
            per_mem[free_slot]    <= duration;
            repeat_reg[free_slot] <= repeat_flag;
        end
        if (scan_run)
        begin
            exp_rd_reg  <= exp_mem[scan_slot];
            rd_slot_reg <= scan_slot;
        end
        if (cmd.fire_read)
        begin
            per_rd_reg <= per_mem[best_reg];
            fired_reg  <= best_reg;
        end
        if (cand && (!found_reg || age > best_age_reg))
        begin
            best_reg     <= rd_slot_reg;
            best_age_reg <= age;
        end
        // Build the event
        if (cmd.do_start)
        begin
            kind_reg <= any_free ? EV_STARTED : EV_FULL;
            id_reg   <= any_free ? ID_W'(free_slot) : '0;
            last_reg <= 1'b1;
        end
        else if (cmd.do_cancel)
        begin
            kind_reg <= cancel_ok ? EV_CANCELLED : EV_NOT_ACTIVE;
            id_reg   <= cancel_id;
            last_reg <= 1'b1;
        end
        else if (cmd.emit_fire)
        begin
            kind_reg <= EV_FIRED;
            id_reg   <= ID_W'(fired_reg);
            last_reg <= cmd.emit_last || !found_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            active_reg     <= '0;
            done_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            have_fired_reg <= 1'b0;
            fire_cnt_reg   <= '0;
        end
        else
        begin
            // Table updates from start and cancel
            if (cmd.do_start && any_free)
            begin
                active_reg[free_slot] <= 1'b1;
            end
            if (cmd.do_cancel && cancel_ok)
            begin
                active_reg[cancel_slot] <= 1'b0;
            end
            // Advance time and open a new tick
            if (cmd.do_tick)
            begin
                counter_reg    <= counter_reg + 1'b1;
                done_reg       <= '0;
                have_fired_reg <= 1'b0;
                fire_cnt_reg   <= '0;
            end
            // Scan sequencing
            if (cmd.scan_begin)
            begin
                scan_cnt_reg <= '0;
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_valid_reg <= scan_run;
                if (scan_run)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (cand)
                begin
                    found_reg <= 1'b1;
                end
            end
            // Fire the chosen slot
            if (cmd.fire_read)
            begin
                done_reg[best_reg] <= 1'b1;
            end
            if (cmd.fire_write)
            begin
                if (!repeat_reg[fired_reg])
                begin
                    active_reg[fired_reg] <= 1'b0;
                end
                fire_cnt_reg   <= fire_cnt_reg + 1'b1;
                have_fired_reg <= 1'b1;
            end
        end
    end

    // Status and outputs
    assign sts.scan_done  = (scan_cnt_reg == CNT_W'(NUM_SLOTS)) && !rd_valid_reg;
    assign sts.found      = found_reg;
    assign sts.have_fired = have_fired_reg;
    assign sts.cap_hit    = (fire_cnt_reg == FCNT_W'(MAX_FIRES - 1));
    assign sts.out_last   = last_reg;

    assign event_kind = kind_reg;
    assign slot_id    = id_reg;
    assign time_now   = counter_reg;
    assign last       = last_reg;

    // Checks
    a_fire_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire_write |-> active_reg[fired_reg])
        else $error("fire of a slot that is not active");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_tick |=> counter_reg == $past(counter_reg) + 1'b1)
        else $error("counter did not advance by one on a tick");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(NUM_SLOTS))
        else $error("scan counter ran past the table");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FCNT_W'(MAX_FIRES))
        else $error("more fires in one tick than allowed");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_fire |-> (have_fired_reg || cmd.fire_write))
        else $error("fire event with no fired slot");

endmodule

`default_nettype wire

>>> rtl/core/virtual_timer_multiplexer.sv
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer : virtual timers on one microsecond counter
// Top level: joins the sequencing controller to the timer table datapath.
// ----------------------------------------------------------------------------
// Up to 16 timers share one free-running 32-bit counter that a tick beat
// advances by one. A start beat takes the lowest free slot and offers one
// event in the cycle after acceptance; a cancel beat does the same. A tick
// beat scans the table one slot per cycle through the expiry memory, and a
// tick that fires F timers runs F + 1 scans (one fewer when it reaches the
// cap of 16 fires); a tick with nothing due gives no event. Fires come
// oldest expiry first, lowest slot on ties, at most 16 per tick. One item is
// in work at a time: in_ready is high only when the previous item is fully
// delivered. time_now shows the counter.
`default_nettype none

module virtual_timer_multiplexer
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [vtm_pkg::OP_W-1:0]   opcode,
    input  wire logic [vtm_pkg::TIME_W-1:0] duration,
    input  wire logic                       repeat_flag,
    input  wire logic [vtm_pkg::ID_W-1:0]   cancel_id,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [vtm_pkg::KIND_W-1:0]      event_kind,
    output logic [vtm_pkg::ID_W-1:0]        slot_id,
    output logic [vtm_pkg::TIME_W-1:0]      time_now,
    output logic                            last
);
    import vtm_pkg::*;

    vtm_cmd_t cmd;
    vtm_sts_t sts;

    // Sequencing
    vtm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Timer table
    vtm_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .duration    (duration),
        .repeat_flag (repeat_flag),
        .cancel_id   (cancel_id),
        .event_kind  (event_kind),
        .slot_id     (slot_id),
        .time_now    (time_now),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

>>> sim/virtual_timer_multiplexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer_tb : self-checking bench for the timer multiplexer
// Walks a short table of hand-picked beats, then random and well-formed
// start/tick/cancel sequences. A behavioural copy of the slot table predicts
// each event not fixed by a table row and compares it with what the block returns.
// ----------------------------------------------------------------------------
module virtual_timer_multiplexer_tb;

    import vtm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;   // unused code, acts as a tick
    localparam int              N_ITEMS    = 220;
    localparam int              N_ROWS     = 26;
    localparam int              CYCLE_CAP  = 1000000;
    localparam int              SETTLE     = NUM_SLOTS + 8;
    localparam logic [TIME_W-1:0] T_MAX    = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] T_HALF   = 32'h8000_0000;
    localparam logic [TIME_W-1:0] T_BELOW  = 32'h7FFF_FFFF;

    // How a stimulus row is checked
    typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_e;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] dur;
        logic              rep;
        logic [ID_W-1:0]   cid;
        row_check_e        check;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   slot;
        logic [TIME_W-1:0] now;
    } stim_row_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   slot;
        logic [TIME_W-1:0] now;
        logic              last;
    } tmr_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   opcode = OP_TICK;
    logic [TIME_W-1:0] duration = '0;
    logic              repeat_flag = 1'b0;
    logic [ID_W-1:0]   cancel_id = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   slot_id;
    logic [TIME_W-1:0] time_now;
    logic              last;

    // Beat currently offered, with its checking mode
    stim_row_t cur_row = '{OP_TICK, '0, 1'b0, '0, BY_MODEL, '0, '0, '0};

    // Predicted slot table
    logic [TIME_W-1:0] tmr_now;
    logic [TIME_W-1:0] tmr_expiry [NUM_SLOTS];
    logic [TIME_W-1:0] tmr_period [NUM_SLOTS];
    logic              tmr_active [NUM_SLOTS];
    logic              tmr_repeat [NUM_SLOTS];

    tmr_result_t step_results[$];
    tmr_result_t pending_results[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          cycles = 0;
    logic [8:0]  stall_phase = '0;
    stim_row_t   stim_table [N_ROWS];

    virtual_timer_multiplexer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .duration    (duration),
        .repeat_flag (repeat_flag),
        .cancel_id   (cancel_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .slot_id     (slot_id),
        .time_now    (time_now),
        .last        (last)
    );

    always #1 clk = ~clk;

    // Work out the events one accepted beat causes, and update the table
    function automatic void schedule_timers(input logic [OP_W-1:0] op,
                                            input logic [TIME_W-1:0] dur,
                                            input logic rep,
                                            input logic [ID_W-1:0] cid);
        int          found;
        int          best;
        logic [31:0] age;
        logic [31:0] best_age;
        logic        fired [NUM_SLOTS];
        tmr_result_t r;

        step_results.delete();
        found = -1;
        if (op == OP_START)
        begin
            for (int s = NUM_SLOTS - 1; s >= 0; s--)
                if (!tmr_active[s])
                    found = s;
            if (found < 0)
                step_results.push_back('{EV_FULL, '0, tmr_now, 1'b0});
            else
            begin
                tmr_active[found] = 1'b1;
                tmr_repeat[found] = rep;
                tmr_period[found] = dur;
                tmr_expiry[found] = tmr_now + dur;
                step_results.push_back('{EV_STARTED, ID_W'(found), tmr_now, 1'b0});
            end
        end
        else if (op == OP_CANCEL)
        begin
            if (int'(cid) < NUM_SLOTS && tmr_active[cid])
            begin
                tmr_active[cid] = 1'b0;
                step_results.push_back('{EV_CANCELLED, cid, tmr_now, 1'b0});
            end
            else
                step_results.push_back('{EV_NOT_ACTIVE, cid, tmr_now, 1'b0});
        end
        else
        begin
            // Advance the counter and fire due timers, oldest first
            for (int s = 0; s < NUM_SLOTS; s++)
                fired[s] = 1'b0;
            tmr_now = tmr_now + 1;
            for (int n = 0; n < MAX_FIRES; n++)
            begin
                best = -1;
                best_age = '0;
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    age = tmr_now - tmr_expiry[s];
                    if (tmr_active[s] && !fired[s] && !age[31] &&
                        (best < 0 || age > best_age))
                    begin
                        best = s;
                        best_age = age;
                    end
                end
                if (best < 0)
                    break;
                fired[best] = 1'b1;
                if (tmr_repeat[best])
                    tmr_expiry[best] = tmr_now + tmr_period[best];
                else
                    tmr_active[best] = 1'b0;
                step_results.push_back('{EV_FIRED, ID_W'(best), tmr_now, 1'b0});
            end
        end
        // Mark the final event of the beat
        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
        end
    endfunction

    function automatic stim_row_t make_row(input logic [OP_W-1:0] op,
                                           input logic [TIME_W-1:0] dur,
                                           input logic rep,
                                           input logic [ID_W-1:0] cid);
        return '{op, dur, rep, cid, BY_MODEL, '0, '0, '0};
    endfunction

    task automatic note_mismatch(input string what, input tmr_result_t want,
                                 input tmr_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("mismatch (%s): want kind %0d slot %0d now %0d last %0b",
                   what, want.kind, want.slot, want.now, want.last);
            $display(", got kind %0d slot %0d now %0d last %0b",
                     got.kind, got.slot, got.now, got.last);
        end
    endtask

    // Predict on each accepted input beat, check each accepted output beat
    always @(posedge clk)
    begin
        tmr_result_t got;
        tmr_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                schedule_timers(cur_row.op, cur_row.dur, cur_row.rep, cur_row.cid);
                case (cur_row.check)
                    BY_MODEL:
                        foreach (step_results[i])
                            pending_results.push_back(step_results[i]);
                    ONE_RESULT:
                        pending_results.push_back('{cur_row.kind, cur_row.slot,
                                                    cur_row.now, 1'b1});
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{event_kind, slot_id, time_now, last};
                if (pending_results.size() == 0)
                    note_mismatch("unexpected beat", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_mismatch("field", want, got);
                end
            end
        end
    end

    // Stall the receiver on a rotating pattern
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[8:7])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= stall_phase[2];
            default: out_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Offer one beat, in bursts with random gaps, and hold until accepted
    task automatic send_item(input stim_row_t r);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid    <= 1'b1;
        cur_row     <= r;
        opcode      <= r.op;
        duration    <= r.dur;
        repeat_flag <= r.rep;
        cancel_id   <= r.cid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold off until every predicted event has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Fill the table past full, tick a few times, then cancel every slot
    task automatic fill_and_drain();
        for (int i = 0; i <= NUM_SLOTS; i++)
            send_item(make_row(OP_START, TIME_W'($urandom_range(1, 4)),
                               1'($urandom_range(0, 1)), '0));
        repeat (6)
            send_item(make_row(OP_TICK, $urandom(), 1'($urandom_range(0, 1)),
                               ID_W'($urandom_range(0, 15))));
        for (int i = 0; i < NUM_SLOTS; i++)
            send_item(make_row(OP_CANCEL, $urandom(), 1'($urandom_range(0, 1)),
                               ID_W'(i)));
    endtask

    task automatic random_mix(input int count);
        int                pick;
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] dur;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_TICK;
            else if (pick < 50)
                op = OP_SPARE;
            else if (pick < 78)
                op = OP_START;
            else
                op = OP_CANCEL;
            // Mostly short durations, with the wrap boundary now and then
            pick = $urandom_range(0, 99);
            if (pick < 60)
                dur = TIME_W'($urandom_range(0, 6));
            else if (pick < 75)
                dur = TIME_W'($urandom_range(7, 40));
            else if (pick < 85)
                dur = $urandom();
            else if (pick < 90)
                dur = T_MAX;
            else if (pick < 95)
                dur = T_HALF;
            else
                dur = T_BELOW;
            send_item(make_row(op, dur, ($urandom_range(0, 9) < 3),
                               ID_W'($urandom_range(0, 15))));
        end
    endtask

    // Stop a hung run
    initial
    begin
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int pick;

        // Directed rows: fixed results where plain, the predictor elsewhere
        stim_table = '{
            '{OP_CANCEL, '0,      1'b0, 4'd0,  ONE_RESULT, EV_NOT_ACTIVE, 4'd0,  32'd0},
            '{OP_CANCEL, '0,      1'b0, 4'd15, ONE_RESULT, EV_NOT_ACTIVE, 4'd15, 32'd0},
            '{OP_TICK,   '0,      1'b0, 4'd0,  NO_RESULT,  EV_STARTED,    4'd0,  32'd0},
            '{OP_START,  '0,      1'b0, 4'd0,  ONE_RESULT, EV_STARTED,    4'd0,  32'd1},
            '{OP_TICK,   '0,      1'b0, 4'd0,  ONE_RESULT, EV_FIRED,      4'd0,  32'd2},
            '{OP_START,  '0,      1'b1, 4'd0,  ONE_RESULT, EV_STARTED,    4'd0,  32'd2},
            '{OP_TICK,   '0,      1'b0, 4'd0,  ONE_RESULT, EV_FIRED,      4'd0,  32'd3},
            '{OP_SPARE,  '0,      1'b0, 4'd0,  ONE_RESULT, EV_FIRED,      4'd0,  32'd4},
            '{OP_CANCEL, '0,      1'b0, 4'd0,  ONE_RESULT, EV_CANCELLED,  4'd0,  32'd4},
            '{OP_CANCEL, '0,      1'b0, 4'd0,  ONE_RESULT, EV_NOT_ACTIVE, 4'd0,  32'd4},
            '{OP_START,  T_MAX,   1'b0, 4'd0,  ONE_RESULT, EV_STARTED,    4'd0,  32'd4},
            '{OP_START,  T_HALF,  1'b1, 4'd0,  ONE_RESULT, EV_STARTED,    4'd1,  32'd4},
            '{OP_START,  T_BELOW, 1'b0, 4'd0,  ONE_RESULT, EV_STARTED,    4'd2,  32'd4},
            '{OP_START,  32'd2,   1'b1, 4'd0,  ONE_RESULT, EV_STARTED,    4'd3,  32'd4},
            '{OP_START,  32'd2,   1'b0, 4'd0,  ONE_RESULT, EV_STARTED,    4'd4,  32'd4},
            '{OP_START,  32'd1,   1'b0, 4'd0,  ONE_RESULT, EV_STARTED,    4'd5,  32'd4},
            '{OP_TICK,   T_MAX,   1'b1, 4'd15, BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_TICK,   '0,      1'b0, 4'd0,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_TICK,   '0,      1'b0, 4'd0,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_TICK,   '0,      1'b0, 4'd0,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_START,  T_MAX,   1'b1, 4'd0,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_CANCEL, '0,      1'b0, 4'd3,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_CANCEL, '0,      1'b0, 4'd1,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_CANCEL, '0,      1'b0, 4'd2,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_TICK,   '0,      1'b0, 4'd0,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0},
            '{OP_CANCEL, '0,      1'b0, 4'd0,  BY_MODEL,   EV_STARTED,    4'd0,  32'd0}
        };

        // Clear the predicted table and hold reset
        tmr_now = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
            tmr_active[s] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_item(stim_table[i]);
        wait_for_drain();

        // Random phase: mixed traffic, table fills, and full drains
        fill_and_drain();
        while (items_sent < N_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                fill_and_drain();
            else if (pick == 1)
                wait_for_drain();
            else
                random_mix($urandom_range(5, 30));
        end

        wait_for_drain();
        repeat (2 * SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
